>>> src/tip_pkg.sv
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types, codes and character helpers for the text-to-integer parser.
// ----------------------------------------------------------------------------
package tip_pkg;

  localparam int unsigned ValW  = 64;
  localparam int unsigned PosW  = 16;
  localparam int unsigned BaseW = 6;
  localparam int unsigned DigW  = 7;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NO_DIGITS      = 2'd1,
    ST_MINUS_UNSIGNED = 2'd2,
    ST_RANGE          = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_NUMBER_BASE   = 2'd0,
    CFG_UNSIGNED_MODE = 2'd1,
    CFG_WIDE_MODE     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [BaseW-1:0] number_base;
    logic             unsigned_mode;
    logic             wide_mode;
  } cfg_t;

  // parse state captured on the last beat of a string
  typedef struct packed {
    logic [ValW-1:0] acc;
    logic            neg;
    logic            digit;
    logic            ovf;
    logic            early_minus;
    logic [PosW-1:0] stop;
  } snap_t;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [BaseW-1:0] BASE_8  = 6'd8;
  localparam logic [BaseW-1:0] BASE_10 = 6'd10;
  localparam logic [BaseW-1:0] BASE_16 = 6'd16;

  localparam logic [DigW-1:0] DIGIT_NONE = 7'd64;

  function automatic logic [DigW-1:0] digit_of(input logic [7:0] c);
    logic [DigW-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) d = DigW'(c - CH_0);
    else if (c >= CH_UA && c <= CH_UZ) d = DigW'(c - CH_UA) + 7'd10;
    else if (c >= CH_LA && c <= CH_LZ) d = DigW'(c - CH_LA) + 7'd10;
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> src/tip_in_stage.sv
// ----------------------------------------------------------------------------
// tip_in_stage
// Input register: holds one text beat until the scanner takes it.
// ----------------------------------------------------------------------------
module tip_in_stage
  import tip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_tready = !valid_r || take_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign valid_o = valid_r;
  assign byte_o  = byte_r;
  assign last_o  = last_r;

endmodule

>>> src/tip_scan.sv
// ----------------------------------------------------------------------------
// tip_scan
// Per-byte parse step: whitespace, sign, prefix and digit accumulation.
// ----------------------------------------------------------------------------
module tip_scan
  import tip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       take_o,
  output logic       snap_valid_o,
  output snap_t      snap_o,
  input  logic       snap_take_i
);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [BaseW-1:0] base_r, base_nxt;
  logic [ValW-1:0]  acc_r, acc_nxt;
  logic             digit_r, digit_nxt;
  logic             ovf_r, ovf_nxt;
  logic             early_r, early_nxt;
  logic [PosW-1:0]  pos_r, pos_after;
  logic [PosW-1:0]  stop_r, stop_nxt;
  logic             snap_valid_r;
  snap_t            snap_r;

  logic             first_c, feed_c, fits_c, is_zero_c, is_x_c;
  logic [DigW-1:0]  dig_c;
  logic [ValW-1:0]  lim_c;
  logic [ValW+6:0]  prod_c;

  assign take_o    = valid_i && (!last_i || !snap_valid_r || snap_take_i);
  assign pos_after = (pos_r == {PosW{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign dig_c     = digit_of(byte_i);
  assign is_zero_c = (byte_i == CH_0);
  assign is_x_c    = (byte_i == CH_LX) || (byte_i == CH_UX);
  assign lim_c     = cfg_i.wide_mode ? {ValW{1'b1}} : {32'd0, 32'hFFFF_FFFF};

  always_comb begin
    first_c  = 1'b0;
    base_nxt = base_r;
    case (phase_r)
      PH_SPACE: begin
        first_c = !is_space(byte_i) && byte_i != CH_MINUS && byte_i != CH_PLUS;
      end
      PH_FIRST: first_c = 1'b1;
      PH_ZERO: begin
        if (is_x_c) base_nxt = BASE_16;
        else if (base_r == '0) base_nxt = BASE_8;
      end
      default: ;
    endcase
    if (first_c) begin
      if (cfg_i.number_base != '0) base_nxt = cfg_i.number_base;
      else if (!is_zero_c) base_nxt = BASE_10;
      else base_nxt = '0;
    end
  end

  assign prod_c = (ValW+7)'(acc_r) * (ValW+7)'(base_nxt) + (ValW+7)'(dig_c);
  assign fits_c = prod_c <= (ValW+7)'(lim_c);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    digit_nxt = digit_r;
    ovf_nxt   = ovf_r;
    early_nxt = early_r;
    stop_nxt  = stop_r;
    feed_c    = 1'b0;
    case (phase_r)
      PH_SPACE: begin
        if (byte_i == CH_MINUS) begin
          neg_nxt = 1'b1;
          if (cfg_i.unsigned_mode) begin
            early_nxt = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_FIRST;
          end
        end else if (byte_i == CH_PLUS) begin
          phase_nxt = PH_FIRST;
        end
      end
      PH_ZERO: begin
        if (is_x_c) begin
          phase_nxt = PH_DIGITS;
        end else begin
          digit_nxt = 1'b1;
          feed_c    = 1'b1;
        end
      end
      PH_DIGITS: feed_c = 1'b1;
      default: ;
    endcase
    if (first_c) begin
      if (is_zero_c && (cfg_i.number_base == '0 || cfg_i.number_base == BASE_16)) begin
        stop_nxt  = pos_after;
        phase_nxt = PH_ZERO;
      end else begin
        feed_c = 1'b1;
      end
    end
    if (feed_c) begin
      if (dig_c >= {1'b0, base_nxt} || base_nxt == '0) begin
        stop_nxt  = pos_r;
        phase_nxt = PH_DONE;
      end else begin
        digit_nxt = 1'b1;
        if (fits_c) acc_nxt = prod_c[ValW-1:0];
        else ovf_nxt = 1'b1;
        stop_nxt  = pos_after;
        phase_nxt = PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SPACE;
      neg_r        <= 1'b0;
      base_r       <= '0;
      acc_r        <= '0;
      digit_r      <= 1'b0;
      ovf_r        <= 1'b0;
      early_r      <= 1'b0;
      pos_r        <= '0;
      stop_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (snap_take_i) snap_valid_r <= 1'b0;
      if (take_o && last_i) begin
        snap_valid_r <= 1'b1;
        phase_r      <= PH_SPACE;
        neg_r        <= 1'b0;
        base_r       <= '0;
        acc_r        <= '0;
        digit_r      <= 1'b0;
        ovf_r        <= 1'b0;
        early_r      <= 1'b0;
        pos_r        <= '0;
        stop_r       <= '0;
      end else if (take_o) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        acc_r   <= acc_nxt;
        digit_r <= digit_nxt;
        ovf_r   <= ovf_nxt;
        early_r <= early_nxt;
        pos_r   <= pos_after;
        stop_r  <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o && last_i) begin
      snap_r.acc         <= acc_nxt;
      snap_r.neg         <= neg_nxt;
      snap_r.digit       <= digit_nxt || (phase_nxt == PH_ZERO);
      snap_r.ovf         <= ovf_nxt;
      snap_r.early_minus <= early_nxt;
      snap_r.stop        <= stop_nxt;
    end
  end

  assign snap_valid_o = snap_valid_r;
  assign snap_o       = snap_r;

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    take_o && last_i |=> pos_r == '0 && phase_r == PH_SPACE && !digit_r)
    else $error("parse state not cleared after last beat");

  a_base_set: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r || phase_r == PH_DIGITS |-> base_r != '0)
    else $error("digits taken without a radix");

  a_early_neg: assert property (@(posedge clk) disable iff (!rst_n)
    early_r |-> neg_r && phase_r == PH_DONE)
    else $error("early minus error without minus sign");

endmodule

>>> src/tip_finish.sv
// ----------------------------------------------------------------------------
// tip_finish
// Status, sign and saturation for a finished string; result register.
// ----------------------------------------------------------------------------
module tip_finish
  import tip_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg_i,
  input  logic            snap_valid_i,
  input  snap_t           snap_i,
  output logic            snap_take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ValW-1:0] value_o,
  output status_t         status_o,
  output logic [PosW-1:0] stop_o
);

  logic            out_valid_r;
  logic [ValW-1:0] value_r, value_nxt;
  status_t         status_r, status_nxt;
  logic [PosW-1:0] stop_r, stop_nxt;
  logic [ValW-1:0] lim_c, half_c;

  assign snap_take_o = snap_valid_i && (!out_valid_r || out_ready_i);
  assign lim_c  = cfg_i.wide_mode ? {ValW{1'b1}} : {32'd0, 32'hFFFF_FFFF};
  assign half_c = cfg_i.wide_mode ? {1'b1, 63'd0} : {32'd0, 1'b1, 31'd0};

  always_comb begin
    value_nxt  = snap_i.acc;
    status_nxt = ST_OK;
    stop_nxt   = snap_i.stop;
    if (snap_i.early_minus || (snap_i.neg && cfg_i.unsigned_mode)) begin
      status_nxt = ST_MINUS_UNSIGNED;
      value_nxt  = '0;
      stop_nxt   = '0;
    end else if (!snap_i.digit) begin
      status_nxt = ST_NO_DIGITS;
      value_nxt  = '0;
      stop_nxt   = '0;
    end else if (snap_i.ovf || (!cfg_i.unsigned_mode &&
                 ((snap_i.neg && snap_i.acc > half_c) ||
                  (!snap_i.neg && snap_i.acc > half_c - 1'b1)))) begin
      status_nxt = ST_RANGE;
      if (cfg_i.unsigned_mode) value_nxt = lim_c;
      else if (snap_i.neg) value_nxt = half_c;
      else value_nxt = half_c - 1'b1;
    end
    if (snap_i.neg && status_nxt != ST_MINUS_UNSIGNED) value_nxt = '0 - value_nxt;
    value_nxt = value_nxt & lim_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready_i) begin
      out_valid_r <= snap_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take_o) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
      stop_r   <= stop_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign value_o     = value_r;
  assign status_o    = status_r;
  assign stop_o      = stop_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_NO_DIGITS || status_r == ST_MINUS_UNSIGNED)
      |-> value_r == '0 && stop_r == '0)
    else $error("error result carries value or stop position");

endmodule

>>> src/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming ASCII-to-integer parser with base detection and saturation.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle, sustained, with no gaps between strings,
// while the result side takes its beats. Each byte passes an input register,
// one parse step (a 64x6 multiply-add with limit compare sets the cycle), a
// capture register and then the result register, which holds the result
// beat for a string; only the last byte of a string yields a beat.
// Parse state clears on that byte, with no start-up pass after reset.
// Configuration writes take effect in the next cycle and belong between
// strings.
module text_to_integer_parser
  import tip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [63:0] parsed_value, [65:64] parse_status,
                                  // [81:66] stop_position, [87:82] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  cfg_t            cfg_r;
  logic            stage_valid, stage_last, stage_take;
  logic [7:0]      stage_byte;
  logic            snap_valid, snap_take;
  snap_t           snap;
  logic [ValW-1:0] value;
  status_t         status;
  logic [PosW-1:0] stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base   <= BASE_10;
      cfg_r.unsigned_mode <= 1'b0;
      cfg_r.wide_mode     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMBER_BASE:   cfg_r.number_base   <= cfg_data;
        CFG_UNSIGNED_MODE: cfg_r.unsigned_mode <= cfg_data[0];
        CFG_WIDE_MODE:     cfg_r.wide_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tip_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take_i    (stage_take),
    .valid_o   (stage_valid),
    .byte_o    (stage_byte),
    .last_o    (stage_last)
  );

  tip_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .valid_i      (stage_valid),
    .byte_i       (stage_byte),
    .last_i       (stage_last),
    .take_o       (stage_take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_take_i  (snap_take)
  );

  tip_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_take_o  (snap_take),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .value_o      (value),
    .status_o     (status),
    .stop_o       (stop)
  );

  assign out_tdata = {6'd0, stop, status, value};

endmodule

>>> test/tb_text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// tb_text_to_integer_parser
// Streams ASCII strings into the parser and compares every result beat, field
// by field, against a table row or a cycle-free parse model held in this
// bench. A directed table covers type limits, base detection, prefixes and
// error codes; random strings under changing settings follow, with random
// gaps on both sides and a long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_text_to_integer_parser;
  import tip_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS  = 1340;
  localparam int unsigned CHOKE_CYCLES  = 400;
  localparam int          NUM_ROWS      = 25;

  typedef enum logic [2:0] {
    SCAN_SPACE, SCAN_SIGN, SCAN_ZERO, SCAN_DIGITS, SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic [15:0] stop;
  } parse_result_t;

  typedef struct {
    logic [5:0]  base;
    bit          uns;
    bit          wide;
    string       text;
    bit          typed;
    logic [63:0] value;
    status_t     status;
    logic [15:0] stop;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // [63:0] parsed_value, [65:64] parse_status,
                           // [81:66] stop_position, [87:82] zero
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  // settings mirror
  logic [5:0] cfg_base_m = 6'd10;
  bit         cfg_uns_m  = 1'b0;
  bit         cfg_wide_m = 1'b1;

  // parse state mirror
  scan_phase_t scan_phase     = SCAN_SPACE;
  bit          saw_minus      = 1'b0;
  logic [5:0]  radix          = '0;
  logic [63:0] acc            = '0;
  bit          got_digit      = 1'b0;
  bit          got_ovf        = 1'b0;
  logic [15:0] char_pos       = '0;
  logic [15:0] stop_pos       = '0;
  bit          minus_rejected = 1'b0;

  parse_result_t expected_q[$];
  logic [7:0]    text_q[$];
  bit            row_typed = 1'b0;
  parse_result_t row_expect;
  bit            src_idle_on = 1'b1;
  bit            snk_idle_on = 1'b1;
  int unsigned   choke_cycles = 0;
  int unsigned   err_count = 0;
  int unsigned   idle_run = 0;

  directed_row_t dir_rows [NUM_ROWS] = '{
    '{6'd10, 1'b0, 1'b1, "0", 1'b1, 64'd0, ST_OK, 16'd1},
    '{6'd10, 1'b0, 1'b1, "  -9223372036854775808", 1'b1,
      64'h8000_0000_0000_0000, ST_OK, 16'd22},
    '{6'd10, 1'b0, 1'b1, "9223372036854775808", 1'b1,
      64'h7FFF_FFFF_FFFF_FFFF, ST_RANGE, 16'd19},
    '{6'd10, 1'b0, 1'b1, "\t+123abc", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd10, 1'b0, 1'b1, "xyz", 1'b1, 64'd0, ST_NO_DIGITS, 16'd0},
    '{6'd10, 1'b0, 1'b1, " \n\013\014\015\011", 1'b1, 64'd0, ST_NO_DIGITS, 16'd0},
    '{6'd10, 1'b1, 1'b1, "18446744073709551615", 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF, ST_OK, 16'd20},
    '{6'd10, 1'b1, 1'b1, "184467440737095516150", 1'b1,
      64'hFFFF_FFFF_FFFF_FFFF, ST_RANGE, 16'd21},
    '{6'd10, 1'b1, 1'b1, "-5", 1'b1, 64'd0, ST_MINUS_UNSIGNED, 16'd0},
    '{6'd10, 1'b1, 1'b0, "4294967296", 1'b1, 64'hFFFF_FFFF, ST_RANGE, 16'd10},
    '{6'd10, 1'b0, 1'b0, "-2147483648", 1'b1, 64'h8000_0000, ST_OK, 16'd11},
    '{6'd10, 1'b0, 1'b0, "2147483648", 1'b1, 64'h7FFF_FFFF, ST_RANGE, 16'd10},
    '{6'd10, 1'b0, 1'b0, "-2147483649", 1'b1, 64'h8000_0000, ST_RANGE, 16'd11},
    '{6'd0, 1'b0, 1'b1, "0x1F", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd0, 1'b0, 1'b1, "0X", 1'b1, 64'd0, ST_NO_DIGITS, 16'd0},
    '{6'd0, 1'b0, 1'b1, "0xg", 1'b1, 64'd0, ST_NO_DIGITS, 16'd0},
    '{6'd0, 1'b0, 1'b1, "0", 1'b1, 64'd0, ST_OK, 16'd1},
    '{6'd0, 1'b0, 1'b1, "0178", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd0, 1'b0, 1'b1, "z", 1'b1, 64'd0, ST_NO_DIGITS, 16'd0},
    '{6'd16, 1'b0, 1'b1, "-0x8000000000000000", 1'b1,
      64'h8000_0000_0000_0000, ST_OK, 16'd19},
    '{6'd16, 1'b1, 1'b1, "0xfFz\377", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd36, 1'b0, 1'b1, "zZ", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd2, 1'b1, 1'b0, "+1012", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd1, 1'b0, 1'b1, "0010", 1'b0, 64'd0, ST_OK, 16'd0},
    '{6'd63, 1'b1, 1'b1, "zzzzzzzzzzzz9", 1'b0, 64'd0, ST_OK, 16'd0}
  };

  text_to_integer_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [6:0] char_to_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 7'(c - "0");
    if (c >= "A" && c <= "Z") return 7'(c - "A" + 10);
    if (c >= "a" && c <= "z") return 7'(c - "a" + 10);
    return 7'd64;
  endfunction

  function automatic logic [63:0] type_limit();
    return cfg_wide_m ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR @%0t %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic take_digit(input logic [7:0] c, input logic [15:0] at,
                            input logic [15:0] nxt);
    logic [6:0]  d;
    logic [63:0] lim;
    logic [63:0] b;
    logic [63:0] q;
    d = char_to_digit(c);
    if (radix == 6'd0 || d >= 7'(radix)) begin
      stop_pos   = at;
      scan_phase = SCAN_DONE;
    end else begin
      got_digit = 1'b1;
      lim = type_limit();
      b   = 64'(radix);
      q   = lim / b;
      if (acc < q || (acc == q && 64'(d) <= lim % b)) acc = acc * b + 64'(d);
      else got_ovf = 1'b1;
      stop_pos   = nxt;
      scan_phase = SCAN_DIGITS;
    end
  endtask

  task automatic start_number(input logic [7:0] c, input logic [15:0] at,
                              input logic [15:0] nxt);
    if ((cfg_base_m == 6'd0 || cfg_base_m == 6'd16) && c == "0") begin
      radix      = cfg_base_m;
      stop_pos   = nxt;
      scan_phase = SCAN_ZERO;
    end else begin
      radix = (cfg_base_m == 6'd0) ? 6'd10 : cfg_base_m;
      take_digit(c, at, nxt);
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input bit last,
                            output bit produced, output parse_result_t res);
    logic [15:0] at;
    logic [15:0] nxt;
    logic [63:0] lim;
    logic [63:0] half;
    logic [63:0] val;
    logic [15:0] stp;
    status_t     st;
    at       = char_pos;
    nxt      = (at == 16'hFFFF) ? at : at + 16'd1;
    char_pos = nxt;
    case (scan_phase)
      SCAN_SPACE: begin
        if (!(c == " " || (c >= 8'h09 && c <= 8'h0D))) begin
          if (c == "-") begin
            saw_minus = 1'b1;
            if (cfg_uns_m) begin
              minus_rejected = 1'b1;
              scan_phase     = SCAN_DONE;
            end else begin
              scan_phase = SCAN_SIGN;
            end
          end else if (c == "+") begin
            scan_phase = SCAN_SIGN;
          end else begin
            start_number(c, at, nxt);
          end
        end
      end
      SCAN_SIGN: start_number(c, at, nxt);
      SCAN_ZERO: begin
        if (c == "x" || c == "X") begin
          radix      = 6'd16;
          scan_phase = SCAN_DIGITS;
        end else begin
          if (radix == 6'd0) radix = 6'd8;
          got_digit = 1'b1;
          take_digit(c, at, nxt);
        end
      end
      SCAN_DIGITS: take_digit(c, at, nxt);
      default: begin
      end
    endcase

    produced = last;
    res      = '0;
    if (last) begin
      if (scan_phase == SCAN_ZERO) got_digit = 1'b1;
      lim  = type_limit();
      half = cfg_wide_m ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      val  = acc;
      stp  = stop_pos;
      st   = ST_OK;
      if (minus_rejected || (saw_minus && cfg_uns_m)) begin
        st  = ST_MINUS_UNSIGNED;
        val = '0;
        stp = '0;
      end else if (!got_digit) begin
        st  = ST_NO_DIGITS;
        val = '0;
        stp = '0;
      end else if (got_ovf || (!cfg_uns_m && ((saw_minus && val > half) ||
                                              (!saw_minus && val > half - 1)))) begin
        st  = ST_RANGE;
        val = cfg_uns_m ? lim : (saw_minus ? half : half - 1);
      end
      if (saw_minus && st != ST_MINUS_UNSIGNED) val = -val;
      res.value  = val & lim;
      res.status = st;
      res.stop   = stp;

      scan_phase     = SCAN_SPACE;
      saw_minus      = 1'b0;
      radix          = '0;
      acc            = '0;
      got_digit      = 1'b0;
      got_ovf        = 1'b0;
      char_pos       = '0;
      stop_pos       = '0;
      minus_rejected = 1'b0;
    end
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic send_text();
    int unsigned   gap;
    int            i;
    bit            produced;
    parse_result_t res;
    for (i = 0; i < text_q.size(); i++) begin
      gap = src_idle_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = text_q[i];
      in_tlast  = (i == text_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      parse_byte(text_q[i], in_tlast, produced, res);
      if (produced) expected_q.push_back(row_typed ? row_expect : res);
      @(negedge clk);
    end
  endtask

  task automatic set_config(input logic [5:0] base, input bit uns, input bit wide);
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_NUMBER_BASE;
    cfg_data  = base;
    @(negedge clk);
    cfg_index = CFG_UNSIGNED_MODE;
    cfg_data  = 6'(uns);
    @(negedge clk);
    cfg_index = CFG_WIDE_MODE;
    cfg_data  = 6'(wide);
    @(negedge clk);
    cfg_we     = 1'b0;
    cfg_base_m = base;
    cfg_uns_m  = uns;
    cfg_wide_m = wide;
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (choke_cycles != 0) begin
        out_tready = 1'b0;
        repeat (choke_cycles) @(negedge clk);
        choke_cycles = 0;
      end
      stall = snk_idle_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("beat with no string pending", out_tdata[63:0], 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[63:0] !== want.value)
          report_mismatch("parsed_value", out_tdata[63:0], want.value);
        if (out_tdata[65:64] !== want.status)
          report_mismatch("parse_status", 64'(out_tdata[65:64]), 64'(want.status));
        if (out_tdata[81:66] !== want.stop)
          report_mismatch("stop_position", 64'(out_tdata[81:66]), 64'(want.stop));
        if (out_tdata[87:82] !== 6'd0)
          report_mismatch("pad bits", 64'(out_tdata[87:82]), 64'd0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
    else idle_run = idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", idle_run);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          r;
    int          k;
    int          s;
    int          n;
    int          phase;
    int unsigned random_items;
    int unsigned pick;
    int unsigned dmax;
    int unsigned len;
    logic [5:0]  base;
    logic [5:0]  radix_g;
    logic [63:0] v;
    logic [63:0] lim_g;
    logic [63:0] half_g;
    logic [7:0]  rev[$];

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_NUMBER_BASE;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].base != cfg_base_m || dir_rows[r].uns != cfg_uns_m ||
          dir_rows[r].wide != cfg_wide_m)
        set_config(dir_rows[r].base, dir_rows[r].uns, dir_rows[r].wide);
      text_q = {};
      for (k = 0; k < dir_rows[r].text.len(); k++) text_q.push_back(dir_rows[r].text[k]);
      row_typed  = dir_rows[r].typed;
      row_expect = '{dir_rows[r].value, dir_rows[r].status, dir_rows[r].stop};
      send_text();
    end
    row_typed = 1'b0;

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 6:    base = 6'd0;
        1:       base = 6'd2;
        2:       base = 6'd8;
        3, 7:    base = 6'd10;
        4:       base = 6'd16;
        5:       base = 6'd36;
        default: base = 6'($urandom_range(0, 63));
      endcase
      set_config(base, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);

      if (phase == 3) begin
        // hold the result side while single-byte strings keep coming
        src_idle_on  = 1'b0;
        snk_idle_on  = 1'b0;
        choke_cycles = CHOKE_CYCLES;
        for (s = 0; s < 60; s++) begin
          text_q = {};
          text_q.push_back(digit_char($urandom_range(0, 9)));
          random_items++;
          send_text();
        end
      end else begin
        n = $urandom_range(8, 30);
        for (s = 0; s < n; s++) begin
          text_q = {};
          if ($urandom_range(0, 6) == 0) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) text_q.push_back(8'($urandom_range(0, 255)));
          end else begin
            if ($urandom_range(0, 3) == 0) begin
              len = $urandom_range(1, 3);
              for (k = 0; k < len; k++)
                text_q.push_back(($urandom_range(0, 5) == 5) ? 8'h20 :
                                 8'(9 + $urandom_range(0, 4)));
            end
            pick = $urandom_range(0, 3);
            if (pick == 0) text_q.push_back("-");
            else if (pick == 1) text_q.push_back("+");
            radix_g = cfg_base_m;
            if (cfg_base_m == 6'd0) begin
              pick = $urandom_range(0, 2);
              if (pick == 0) begin
                text_q.push_back("0");
                text_q.push_back($urandom_range(0, 1) ? "x" : "X");
                radix_g = 6'd16;
              end else if (pick == 1) begin
                text_q.push_back("0");
                radix_g = 6'd8;
              end else begin
                radix_g = 6'd10;
              end
            end else if (cfg_base_m == 6'd16 && $urandom_range(0, 1) == 1) begin
              text_q.push_back("0");
              text_q.push_back($urandom_range(0, 1) ? "x" : "X");
            end
            dmax = (radix_g < 6'd2) ? 0 : ((radix_g > 6'd36) ? 35 : radix_g - 1);
            pick = $urandom_range(0, 9);
            if (pick >= 1 && pick <= 2 && radix_g >= 6'd2 && radix_g <= 6'd36) begin
              // digits of a value at or near a type limit
              lim_g  = cfg_wide_m ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
              half_g = cfg_wide_m ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
              case ($urandom_range(0, 4))
                0:       v = half_g - 1;
                1:       v = half_g;
                2:       v = half_g + 1;
                3:       v = lim_g;
                default: v = lim_g - 64'($urandom_range(0, 3));
              endcase
              rev = {};
              do begin
                rev.push_front(digit_char(32'(v % 64'(radix_g))));
                v = v / 64'(radix_g);
              end while (v != 0);
              for (k = 0; k < rev.size(); k++) text_q.push_back(rev[k]);
              if ($urandom_range(0, 3) == 0) text_q.push_back(digit_char(0));
            end else if (pick >= 3) begin
              len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70) :
                                                  $urandom_range(1, 12);
              for (k = 0; k < len; k++) text_q.push_back(digit_char($urandom_range(0, dmax)));
            end
            if ($urandom_range(0, 2) == 0) begin
              len = $urandom_range(1, 3);
              for (k = 0; k < len; k++) text_q.push_back(8'($urandom_range(0, 255)));
            end
            if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
          end
          random_items += text_q.size();
          send_text();
        end
      end
      phase++;
    end

    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
src/tip_pkg.sv
src/tip_in_stage.sv
src/tip_scan.sv
src/tip_finish.sv
src/text_to_integer_parser.sv
test/tb_text_to_integer_parser.sv
